FILE: hw/rtl/dual_pump_level_controller_core_macros.svh
// ----------------------------------------------------------------------------
// Dual pump level controller assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DUAL_PUMP_LEVEL_CONTROLLER_CORE_MACROS_SVH
`define DUAL_PUMP_LEVEL_CONTROLLER_CORE_MACROS_SVH
`ifndef SYNTH
`define DPL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define DPL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define DPL_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define DPL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/dpl_pkg.sv
// ----------------------------------------------------------------------------
// Dual pump level controller package
// Shared widths, codes, register file type and controller/datapath links.
// ----------------------------------------------------------------------------
package dpl_pkg;

  localparam int TIME_W     = 32;
  localparam int LEVEL_W    = 10;
  localparam int TEMP_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [TEMP_W-1:0] TEMP_NOT_SET = 16'sh8000;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_TEMP = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READ_PERIOD = 3'd0,
    CFG_TEMP_VALID  = 3'd1,
    CFG_MIN_TEMP    = 3'd2,
    CFG_PUMP1_TH    = 3'd3,
    CFG_PUMP2_TH    = 3'd4,
    CFG_CUTOFF_TH   = 3'd5,
    CFG_MIN_RUN     = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0]  read_period;
    logic [TIME_W-1:0]  temp_valid;
    logic [TEMP_W-1:0]  min_temp;
    logic [LEVEL_W-1:0] pump1_th;
    logic [LEVEL_W-1:0] pump2_th;
    logic [LEVEL_W-1:0] cutoff_th;
    logic [TIME_W-1:0]  min_run;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    read_period: 32'd1000,
    temp_valid:  32'd60000,
    min_temp:    16'd50,
    pump1_th:    10'd600,
    pump2_th:    10'd800,
    cutoff_th:   10'd300,
    min_run:     32'd30000
  };

  typedef struct packed {
    logic load;
    logic expire;
    logic push;
    logic div_start;
    logic pump1;
    logic pump2;
    logic capture;
  } dp_cmd_t;

  typedef struct packed {
    logic is_temp;
    logic due;
    logic div_done;
  } dp_sts_t;

endpackage

FILE: hw/rtl/dpl_ram.sv
// ----------------------------------------------------------------------------
// Dual pump level controller RAM
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dpl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 15,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/dpl_div.sv
// ----------------------------------------------------------------------------
// Dual pump level controller divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dpl_div #(
  parameter int DVD_W = 14,
  parameter int DVS_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    trial    = {rem_r, quo_r[DVD_W-1]};
    ge       = (trial >= {1'b0, divisor});
    diff     = trial - {1'b0, divisor};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/dpl_dp.sv
// ----------------------------------------------------------------------------
// Dual pump level controller datapath
// Temperature state, sample window, mean divider, pump rules, result register.
// ----------------------------------------------------------------------------
`include "dual_pump_level_controller_core_macros.svh"
module dpl_dp #(
  parameter int WINDOW_DEPTH = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dpl_pkg::cfg_t                       cfg,
  input  dpl_pkg::dp_cmd_t                    cmd,
  output dpl_pkg::dp_sts_t                    sts,
  input  logic                                in_action,
  input  logic [dpl_pkg::TIME_W-1:0]          in_time_ms,
  input  logic [dpl_pkg::LEVEL_W-1:0]         in_sensor_sample,
  input  logic signed [dpl_pkg::TEMP_W-1:0]   in_temperature,
  output logic                                out_sampled,
  output logic [dpl_pkg::LEVEL_W-1:0]         out_latest_level,
  output logic [dpl_pkg::LEVEL_W-1:0]         out_level_average,
  output logic                                out_pump1_running,
  output logic                                out_pump2_running,
  output logic                                out_temperature_ok
);
  import dpl_pkg::*;

  localparam int SUM_W = $clog2(WINDOW_DEPTH * 1023 + 1);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  action_t                   action_r, action_nxt;
  logic [TIME_W-1:0]         time_r, time_nxt;
  logic [LEVEL_W-1:0]        sample_r, sample_nxt;
  logic signed [TEMP_W-1:0]  temp_r, temp_nxt;
  logic signed [TEMP_W-1:0]  stored_r, stored_nxt;
  logic [TIME_W-1:0]         deadline_r, deadline_nxt;
  logic [TIME_W-1:0]         last_time_r, last_time_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [IDX_W-1:0]          head_r, head_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [LEVEL_W-1:0]        latest_r, latest_nxt;
  logic [LEVEL_W-1:0]        mean_r, mean_nxt;
  logic                      p1_r, p1_nxt;
  logic                      p2_r, p2_nxt;
  logic [TIME_W-1:0]         stop1_r, stop1_nxt;
  logic [TIME_W-1:0]         stop2_r, stop2_nxt;
  logic                      sampled_r, sampled_nxt;

  logic                      o_sampled_r;
  logic [LEVEL_W-1:0]        o_latest_r;
  logic [LEVEL_W-1:0]        o_mean_r;
  logic                      o_p1_r;
  logic                      o_p2_r;
  logic                      o_tok_r;

  logic [TIME_W-1:0]         deadline_sum;
  logic [TIME_W-1:0]         run_sum;
  logic [TIME_W-1:0]         elapsed;
  logic                      full;
  logic                      temp_ok;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [LEVEL_W-1:0]        ram_rdata;
  logic                      div_done;
  logic [SUM_W-1:0]          div_quo;

  assign deadline_sum = time_r + cfg.temp_valid;
  assign run_sum      = time_r + cfg.min_run;
  assign elapsed      = time_r - last_time_r;
  assign full         = (count_r == CNT_W'(WINDOW_DEPTH));
  assign temp_ok      = (stored_r != TEMP_NOT_SET) && (stored_r >= $signed(cfg.min_temp));
  assign ram_we       = cmd.push;
  assign ram_waddr    = full ? head_r : count_r[IDX_W-1:0];

  assign sts.is_temp  = (action_r == ACT_TEMP);
  assign sts.due      = (elapsed > cfg.read_period);
  assign sts.div_done = div_done;

  dpl_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (sample_r),
    .re    (cmd.expire),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  dpl_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    action_nxt    = action_r;
    time_nxt      = time_r;
    sample_nxt    = sample_r;
    temp_nxt      = temp_r;
    stored_nxt    = stored_r;
    deadline_nxt  = deadline_r;
    last_time_nxt = last_time_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    sum_nxt       = sum_r;
    latest_nxt    = latest_r;
    mean_nxt      = mean_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    stop1_nxt     = stop1_r;
    stop2_nxt     = stop2_r;
    sampled_nxt   = sampled_r;

    if (cmd.load) begin
      action_nxt  = action_t'(in_action);
      time_nxt    = in_time_ms;
      sample_nxt  = in_sensor_sample;
      temp_nxt    = in_temperature;
      sampled_nxt = 1'b0;
    end

    if (cmd.expire) begin
      if (action_r == ACT_TEMP) begin
        if (temp_r != stored_r) begin
          stored_nxt   = (temp_r < $signed(cfg.min_temp)) ? TEMP_NOT_SET : temp_r;
          deadline_nxt = deadline_sum;
        end
      end else if (time_r > deadline_r) begin
        if (stored_r != TEMP_NOT_SET) begin
          stored_nxt   = TEMP_NOT_SET;
          deadline_nxt = deadline_sum;
        end
        p1_nxt = 1'b0;
        p2_nxt = 1'b0;
      end
    end

    if (cmd.push) begin
      sampled_nxt   = 1'b1;
      last_time_nxt = time_r;
      latest_nxt    = sample_r;
      if (full) begin
        sum_nxt  = sum_r - SUM_W'(ram_rdata) + SUM_W'(sample_r);
        head_nxt = (head_r == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_r + 1'b1;
      end else begin
        sum_nxt   = sum_r + SUM_W'(sample_r);
        count_nxt = count_r + 1'b1;
      end
    end

    if (div_done) begin
      mean_nxt = div_quo[LEVEL_W-1:0];
    end

    if (cmd.pump1) begin
      if (full && temp_ok) begin
        if (p1_r) begin
          if (time_r >= stop1_r || latest_r <= cfg.cutoff_th) begin
            p1_nxt = 1'b0;
          end
        end else if (mean_r >= cfg.pump1_th) begin
          p1_nxt    = 1'b1;
          stop1_nxt = run_sum;
        end
      end else if (!temp_ok) begin
        p1_nxt = 1'b0;
      end
    end

    if (cmd.pump2) begin
      if (full && temp_ok) begin
        if (p2_r) begin
          if (time_r > stop2_r || !p1_r || latest_r < cfg.cutoff_th ||
              latest_r < cfg.pump2_th) begin
            p2_nxt = 1'b0;
          end
        end else if (mean_r > cfg.pump2_th) begin
          p2_nxt    = 1'b1;
          stop2_nxt = run_sum;
        end
      end else if (!temp_ok) begin
        p2_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r    <= TEMP_NOT_SET;
      deadline_r  <= '0;
      last_time_r <= '0;
      count_r     <= '0;
      head_r      <= '0;
      sum_r       <= '0;
      latest_r    <= '0;
      mean_r      <= '0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      stop1_r     <= '0;
      stop2_r     <= '0;
      sampled_r   <= 1'b0;
    end else begin
      stored_r    <= stored_nxt;
      deadline_r  <= deadline_nxt;
      last_time_r <= last_time_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      sum_r       <= sum_nxt;
      latest_r    <= latest_nxt;
      mean_r      <= mean_nxt;
      p1_r        <= p1_nxt;
      p2_r        <= p2_nxt;
      stop1_r     <= stop1_nxt;
      stop2_r     <= stop2_nxt;
      sampled_r   <= sampled_nxt;
    end
    action_r <= action_nxt;
    time_r   <= time_nxt;
    sample_r <= sample_nxt;
    temp_r   <= temp_nxt;
    if (cmd.capture) begin
      o_sampled_r <= sampled_r;
      o_latest_r  <= latest_r;
      o_mean_r    <= mean_r;
      o_p1_r      <= p1_r;
      o_p2_r      <= p2_r;
      o_tok_r     <= temp_ok;
    end
  end

  assign out_sampled        = o_sampled_r;
  assign out_latest_level   = o_latest_r;
  assign out_level_average  = o_mean_r;
  assign out_pump1_running  = o_p1_r;
  assign out_pump2_running  = o_p2_r;
  assign out_temperature_ok = o_tok_r;

  `DPL_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(WINDOW_DEPTH))
  `DPL_ASSERT_IMPL(a_head_until_full, clk, rst_n, !full, head_r == '0)
  `DPL_ASSERT_NEXT(a_push_grows, clk, rst_n, cmd.push && !full, count_r == $past(count_r) + 1'b1)

endmodule

FILE: hw/rtl/dpl_ctrl.sv
// ----------------------------------------------------------------------------
// Dual pump level controller sequencer
// Steps each request through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`include "dual_pump_level_controller_core_macros.svh"
module dpl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dpl_pkg::dp_sts_t  sts,
  output dpl_pkg::dp_cmd_t  cmd
);
  import dpl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_CHECK,
    ST_PUSH,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PUMP1,
    ST_PUMP2,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = (state_r == ST_IDLE);
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXPIRE;
        end
      end
      ST_EXPIRE: begin
        cmd.expire = 1'b1;
        state_nxt  = sts.is_temp ? ST_FINISH : ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = sts.due ? ST_PUSH : ST_FINISH;
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_PUMP1;
        end
      end
      ST_PUMP1: begin
        cmd.pump1 = 1'b1;
        state_nxt = ST_PUMP2;
      end
      ST_PUMP2: begin
        cmd.pump2 = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `DPL_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
  `DPL_ASSERT_IMPL(a_capture_free, clk, rst_n, cmd.capture, !out_valid_r || out_ready)
  `DPL_ASSERT_NEXT(a_capture_shows, clk, rst_n, cmd.capture, out_valid_r && in_ready)

endmodule

FILE: hw/rtl/dual_pump_level_controller_core.sv
// ----------------------------------------------------------------------------
// Dual pump level controller core
// Each request is a time tick with a level sample or a temperature report,
// and yields one result: sample flag, latest level, window mean, both pump
// states and temperature status. One request is in work at a time. Only a
// sampling tick waits on the bit-serial divider that forms the window mean;
// a temperature report and a tick that takes no sample skip it. The result
// sits in an output register, so the next request is taken while it waits.
// The user must write registers through the cfg_ port only while the core
// is idle; the core does not enforce this. cfg_ready is always high.
// ----------------------------------------------------------------------------
module dual_pump_level_controller_core #(
  parameter int WINDOW_DEPTH = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic [dpl_pkg::TIME_W-1:0]          in_time_ms,
  input  logic [dpl_pkg::LEVEL_W-1:0]         in_sensor_sample,
  input  logic signed [dpl_pkg::TEMP_W-1:0]   in_temperature,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_sampled,
  output logic [dpl_pkg::LEVEL_W-1:0]         out_latest_level,
  output logic [dpl_pkg::LEVEL_W-1:0]         out_level_average,
  output logic                                out_pump1_running,
  output logic                                out_pump2_running,
  output logic                                out_temperature_ok,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dpl_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dpl_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_READ_PERIOD: cfg_nxt.read_period = cfg_data;
        CFG_TEMP_VALID:  cfg_nxt.temp_valid  = cfg_data;
        CFG_MIN_TEMP:    cfg_nxt.min_temp    = cfg_data[TEMP_W-1:0];
        CFG_PUMP1_TH:    cfg_nxt.pump1_th    = cfg_data[LEVEL_W-1:0];
        CFG_PUMP2_TH:    cfg_nxt.pump2_th    = cfg_data[LEVEL_W-1:0];
        CFG_CUTOFF_TH:   cfg_nxt.cutoff_th   = cfg_data[LEVEL_W-1:0];
        CFG_MIN_RUN:     cfg_nxt.min_run     = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dpl_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_action),
    .in_time_ms         (in_time_ms),
    .in_sensor_sample   (in_sensor_sample),
    .in_temperature     (in_temperature),
    .out_sampled        (out_sampled),
    .out_latest_level   (out_latest_level),
    .out_level_average  (out_level_average),
    .out_pump1_running  (out_pump1_running),
    .out_pump2_running  (out_pump2_running),
    .out_temperature_ok (out_temperature_ok)
  );

endmodule
